### hw/rtl/mptt_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mptt_pkg
// shared constants and types for the point mover: register map, register
// width, quotient width and register reset values
// ----------------------------------------------------------------------------
package mptt_pkg;

	localparam int REG_W   = 31;
	localparam int QUOT_W  = 31;
	localparam int CIDX_W  = 4;

	localparam logic [REG_W-1:0] SNAP_RST = REG_W'(65536);
	localparam logic [REG_W-1:0] STEP_RST = REG_W'(65536);

	typedef enum logic [CIDX_W-1:0] {
		CFG_SNAP_DIST = 4'd0,
		CFG_STEP_LEN  = 4'd1
	} cfg_idx_t;

endpackage
// ----------------------------------------------------------------------------
`default_nettype wire

### hw/rtl/move_point_toward_target.sv
// pipeline: front stages for difference, magnitude, square and sum, one square
//   root stage per root bit, the snap and step product stage, one divide stage per
//   quotient bit (31), one output stage
// throughput: one item per cycle, busy stays low, done is a one-cycle strobe
// reset: arst_n clears all valid bits and loads both registers with 65536
`default_nettype none
// ----------------------------------------------------------------------------
// move_point_toward_target
// one step of a fixed-point point toward a target point, snapping to the
// target when closer than the snap distance
// ----------------------------------------------------------------------------
module move_point_toward_target #(
	parameter int COORD_WIDTH = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic signed [COORD_WIDTH-1:0]     cur_x,
	input  wire logic signed [COORD_WIDTH-1:0]     cur_y,
	input  wire logic signed [COORD_WIDTH-1:0]     goal_x,
	input  wire logic signed [COORD_WIDTH-1:0]     goal_y,
	output logic                                   done,
	output logic signed [COORD_WIDTH-1:0]          next_x,
	output logic signed [COORD_WIDTH-1:0]          next_y,
	output logic                                   snapped,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire mptt_pkg::cfg_idx_t                cfg_index,
	input  wire logic [31:0]                       cfg_data
);

	import mptt_pkg::*;

	localparam int CW   = COORD_WIDTH;
	localparam int RW   = CW + 1;
	localparam int SW   = 2*RW;
	localparam int PW   = CW + REG_W;
	localparam int CMPW = (RW > REG_W) ? RW : REG_W;
	localparam int EW   = ((CW > QUOT_W) ? CW : QUOT_W) + 2;
	localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (CW-1)) - 64'sd1);
	localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

	typedef struct packed {
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [CW-1:0] gx;
		logic [CW-1:0] gy;
	} pts_t;

	typedef struct packed {
		pts_t          pts;
		logic [CW-1:0] ax;
		logic [CW-1:0] ay;
		logic          neg_x;
		logic          neg_y;
	} root_sb_t;

	typedef struct packed {
		pts_t pts;
		logic neg_x;
		logic neg_y;
		logic snap;
	} div_sb_t;

	logic [REG_W-1:0] snap_q;
	logic [REG_W-1:0] step_q;
	logic             accept;

	logic                vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	pts_t                pts_s1, pts_s2, pts_s3, pts_s4;
	logic signed [CW:0]  dx_s1, dy_s1;
	logic [CW-1:0]       ax_s2, ay_s2, ax_s3, ay_s3, ax_s4, ay_s4;
	logic                nx_s2, ny_s2, nx_s3, ny_s3, nx_s4, ny_s4;
	logic [2*CW-1:0]     sqx_s3, sqy_s3;
	logic [SW-1:0]       sum_s4;

	root_sb_t            rt_sb_in, rt_sb;
	logic                rt_vld;
	logic [RW-1:0]       rt_root;

	logic [RW-1:0]       dist_s5;
	logic [PW-1:0]       px_s5, py_s5;
	div_sb_t             dv_sb_s5;
	logic                snap_c;

	logic                dv_vld;
	logic [QUOT_W-1:0]   dv_qx, dv_qy;
	div_sb_t             dv_sb;
	logic signed [EW-1:0] rx_c, ry_c;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snap_q <= SNAP_RST;
			step_q <= STEP_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_SNAP_DIST: snap_q <= cfg_data[REG_W-1:0];
				CFG_STEP_LEN:  step_q <= cfg_data[REG_W-1:0];
				default: ;
			endcase
		end
	end

	// valid chain of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			done   <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= rt_vld;
			done   <= dv_vld;
		end
	end

	// differences, magnitudes, squares, sum
	always_ff @(posedge clk) begin
		pts_s1 <= '{cx: cur_x, cy: cur_y, gx: goal_x, gy: goal_y};
		dx_s1  <= $signed({goal_x[CW-1], goal_x}) - $signed({cur_x[CW-1], cur_x});
		dy_s1  <= $signed({goal_y[CW-1], goal_y}) - $signed({cur_y[CW-1], cur_y});

		pts_s2 <= pts_s1;
		nx_s2  <= dx_s1[CW];
		ny_s2  <= dy_s1[CW];
		ax_s2  <= dx_s1[CW] ? CW'(-dx_s1) : dx_s1[CW-1:0];
		ay_s2  <= dy_s1[CW] ? CW'(-dy_s1) : dy_s1[CW-1:0];

		pts_s3 <= pts_s2;
		nx_s3  <= nx_s2;
		ny_s3  <= ny_s2;
		ax_s3  <= ax_s2;
		ay_s3  <= ay_s2;
		sqx_s3 <= ax_s2 * ax_s2;
		sqy_s3 <= ay_s2 * ay_s2;

		pts_s4 <= pts_s3;
		nx_s4  <= nx_s3;
		ny_s4  <= ny_s3;
		ax_s4  <= ax_s3;
		ay_s4  <= ay_s3;
		sum_s4 <= SW'(sqx_s3) + SW'(sqy_s3);
	end

	assign rt_sb_in = '{pts: pts_s4, ax: ax_s4, ay: ay_s4, neg_x: nx_s4, neg_y: ny_s4};

	mptt_isqrt #(
		.RootW (RW),
		.SbW   ($bits(root_sb_t))
	) u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s4),
		.in_sq    (sum_s4),
		.in_sb    (rt_sb_in),
		.out_vld  (rt_vld),
		.out_root (rt_root),
		.out_sb   (rt_sb)
	);

	// snap decision and step products
	assign snap_c = (rt_root == '0) || (CMPW'(rt_root) < CMPW'(snap_q));

	always_ff @(posedge clk) begin
		dist_s5  <= rt_root;
		px_s5    <= PW'(rt_sb.ax) * PW'(step_q);
		py_s5    <= PW'(rt_sb.ay) * PW'(step_q);
		dv_sb_s5 <= '{pts: rt_sb.pts, neg_x: rt_sb.neg_x, neg_y: rt_sb.neg_y,
			snap: snap_c};
	end

	mptt_div #(
		.NumW (PW),
		.DenW (RW),
		.SbW  ($bits(div_sb_t))
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s5),
		.in_num_x (px_s5),
		.in_num_y (py_s5),
		.in_den   (dist_s5),
		.in_sb    (dv_sb_s5),
		.out_vld  (dv_vld),
		.out_qx   (dv_qx),
		.out_qy   (dv_qy),
		.out_sb   (dv_sb)
	);

	// signed step and saturation
	always_comb begin
		rx_c = EW'($signed(dv_sb.pts.cx));
		ry_c = EW'($signed(dv_sb.pts.cy));
		if (dv_sb.neg_x) begin
			rx_c = rx_c - $signed(EW'(dv_qx));
		end else begin
			rx_c = rx_c + $signed(EW'(dv_qx));
		end
		if (dv_sb.neg_y) begin
			ry_c = ry_c - $signed(EW'(dv_qy));
		end else begin
			ry_c = ry_c + $signed(EW'(dv_qy));
		end
		if (rx_c > SAT_HI) begin
			rx_c = SAT_HI;
		end else if (rx_c < SAT_LO) begin
			rx_c = SAT_LO;
		end
		if (ry_c > SAT_HI) begin
			ry_c = SAT_HI;
		end else if (ry_c < SAT_LO) begin
			ry_c = SAT_LO;
		end
	end

	always_ff @(posedge clk) begin
		snapped <= dv_sb.snap;
		next_x  <= dv_sb.snap ? $signed(dv_sb.pts.gx) : rx_c[CW-1:0];
		next_y  <= dv_sb.snap ? $signed(dv_sb.pts.gy) : ry_c[CW-1:0];
	end

	// a step never moves farther than the step length on either axis
	a_quot_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dv_vld && !dv_sb.snap |-> (CMPW'(dv_qx) <= CMPW'(step_q)) &&
			(CMPW'(dv_qy) <= CMPW'(step_q)))
		else $error("quotient exceeds step length");

	// a stepped item always has a nonzero distance at or above the snap distance
	a_step_dist: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s5 && !dv_sb_s5.snap |-> (dist_s5 != '0) &&
			(CMPW'(dist_s5) >= CMPW'(snap_q)))
		else $error("stepped with distance below snap distance");

	// the strobe repeats the divider output valid in the following cycle
	a_done_seq: assert property (@(posedge clk) disable iff (!arst_n)
		done == $past(dv_vld))
		else $error("result strobe out of step with pipeline");

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### hw/rtl/mptt_isqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mptt_isqrt
// pipelined integer square root, rounded down, one root bit per stage,
// with a sideband that travels alongside
// ----------------------------------------------------------------------------
module mptt_isqrt #(
	parameter int RootW = 33,
	parameter int SbW   = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_vld,
	input  wire logic [2*RootW-1:0]   in_sq,
	input  wire logic [SbW-1:0]       in_sb,
	output logic                      out_vld,
	output logic [RootW-1:0]          out_root,
	output logic [SbW-1:0]            out_sb
);

	localparam int OW = 2*RootW;

	logic [OW-1:0]  op_s  [0:RootW];
	logic [OW-1:0]  res_s [0:RootW];
	logic [SbW-1:0] sb_s  [0:RootW];
	logic           vld_s [0:RootW];

	assign op_s[0]  = in_sq;
	assign res_s[0] = '0;
	assign sb_s[0]  = in_sb;
	assign vld_s[0] = in_vld;

	for (genvar j = 0; j < RootW; j++) begin : g_stage
		localparam logic [OW-1:0] ONE = OW'(1) << (2*(RootW-1-j));
		logic [OW-1:0] trial;
		logic [OW-1:0] op_n;
		logic [OW-1:0] res_n;

		always_comb begin
			trial = res_s[j] + ONE;
			if (op_s[j] >= trial) begin
				op_n  = op_s[j] - trial;
				res_n = (res_s[j] >> 1) + ONE;
			end else begin
				op_n  = op_s[j];
				res_n = res_s[j] >> 1;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			op_s[j+1]  <= op_n;
			res_s[j+1] <= res_n;
			sb_s[j+1]  <= sb_s[j];
		end
	end

	assign out_vld  = vld_s[RootW];
	assign out_root = res_s[RootW][RootW-1:0];
	assign out_sb   = sb_s[RootW];

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire

### hw/rtl/mptt_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mptt_div
// pipelined restoring divider, two numerators over one shared divisor,
// one quotient bit per stage
// ----------------------------------------------------------------------------
module mptt_div #(
	parameter int NumW = 63,
	parameter int DenW = 33,
	parameter int SbW  = 8
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_vld,
	input  wire logic [NumW-1:0]            in_num_x,
	input  wire logic [NumW-1:0]            in_num_y,
	input  wire logic [DenW-1:0]            in_den,
	input  wire logic [SbW-1:0]             in_sb,
	output logic                            out_vld,
	output logic [mptt_pkg::QUOT_W-1:0]     out_qx,
	output logic [mptt_pkg::QUOT_W-1:0]     out_qy,
	output logic [SbW-1:0]                  out_sb
);

	import mptt_pkg::*;

	localparam int QW = QUOT_W;

	logic [NumW-1:0] nx_s  [0:QW];
	logic [NumW-1:0] ny_s  [0:QW];
	logic [DenW-1:0] rx_s  [0:QW];
	logic [DenW-1:0] ry_s  [0:QW];
	logic [QW-1:0]   qx_s  [0:QW];
	logic [QW-1:0]   qy_s  [0:QW];
	logic [DenW-1:0] den_s [0:QW];
	logic [SbW-1:0]  sb_s  [0:QW];
	logic            vld_s [0:QW];

	assign nx_s[0]  = in_num_x;
	assign ny_s[0]  = in_num_y;
	assign rx_s[0]  = DenW'(in_num_x >> QW);
	assign ry_s[0]  = DenW'(in_num_y >> QW);
	assign qx_s[0]  = '0;
	assign qy_s[0]  = '0;
	assign den_s[0] = in_den;
	assign sb_s[0]  = in_sb;
	assign vld_s[0] = in_vld;

	for (genvar j = 0; j < QW; j++) begin : g_stage
		localparam int B = QW-1-j;
		logic [DenW:0]   tx;
		logic [DenW:0]   ty;
		logic [DenW:0]   dext;
		logic            gex;
		logic            gey;
		logic [DenW-1:0] rx_n;
		logic [DenW-1:0] ry_n;

		always_comb begin
			dext = {1'b0, den_s[j]};
			tx   = {rx_s[j], nx_s[j][B]};
			ty   = {ry_s[j], ny_s[j][B]};
			gex  = (tx >= dext);
			gey  = (ty >= dext);
			rx_n = gex ? DenW'(tx - dext) : tx[DenW-1:0];
			ry_n = gey ? DenW'(ty - dext) : ty[DenW-1:0];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[j+1] <= 1'b0;
			end else begin
				vld_s[j+1] <= vld_s[j];
			end
		end

		always_ff @(posedge clk) begin
			nx_s[j+1]  <= nx_s[j];
			ny_s[j+1]  <= ny_s[j];
			rx_s[j+1]  <= rx_n;
			ry_s[j+1]  <= ry_n;
			qx_s[j+1]  <= {qx_s[j][QW-2:0], gex};
			qy_s[j+1]  <= {qy_s[j][QW-2:0], gey};
			den_s[j+1] <= den_s[j];
			sb_s[j+1]  <= sb_s[j];
		end
	end

	assign out_vld = vld_s[QW];
	assign out_qx  = qx_s[QW];
	assign out_qy  = qy_s[QW];
	assign out_sb  = sb_s[QW];

endmodule
// ----------------------------------------------------------------------------
`default_nettype wire
